### hdl/smq_pkg.sv
// shared constants and types of the sorted multi-queue move engine
package smq_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_QUEUES_DEF  = 3;
    localparam int DATA_WIDTH_DEF  = 32;

    // operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_MOVE   = 2'd2;

    // queue selector as carried on the ports
    typedef logic [1:0] sel_t;

    // command broadcast to every cell of one chain
    typedef struct packed {
        logic ins;
        logic pop;
    } smq_cmd_t;

endpackage

### hdl/smq_cell.sv
// one storage cell of a sorted chain: keeps, takes the key, or takes a neighbor
module smq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  smq_pkg::smq_cmd_t            cmd,
    input  logic signed [DATA_WIDTH-1:0] key,
    input  logic                         occ,
    input  logic                         left_lt,
    input  logic signed [DATA_WIDTH-1:0] left_val,
    input  logic signed [DATA_WIDTH-1:0] right_val,
    output logic signed [DATA_WIDTH-1:0] val,
    output logic                         lt
);
    import smq_pkg::*;

    logic signed [DATA_WIDTH-1:0] val_reg;
    logic signed [DATA_WIDTH-1:0] val_next;

    // occupied and strictly below the key
    assign lt  = occ && (val_reg < key);
    assign val = val_reg;

    // insert opens a gap at the first cell not below the key, pop shifts left
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (lt)
                val_next = val_reg;
            else if (left_lt)
                val_next = key;
            else
                val_next = left_val;
        end
        else if (cmd.pop)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### hdl/smq_chain.sv
// one sorted queue: a row of cells plus its fill count
module smq_chain #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smq_pkg::smq_cmd_t            cmd,
    input  logic signed [DATA_WIDTH-1:0] key,
    output logic signed [DATA_WIDTH-1:0] head,
    output logic                         empty,
    output logic                         full,
    output logic                         last
);
    import smq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic signed [DATA_WIDTH-1:0] val_w [QUEUE_DEPTH];
    logic                         lt_w  [QUEUE_DEPTH];

    // row of cells, each wired to both neighbors
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                         occ;
        logic                         l_lt;
        logic signed [DATA_WIDTH-1:0] l_val;
        logic signed [DATA_WIDTH-1:0] r_val;

        assign occ = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            assign l_lt  = 1'b1;
            assign l_val = key;
        end
        else
        begin : g_inner
            assign l_lt  = lt_w[i-1];
            assign l_val = val_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_val = val_w[i];
        end
        else
        begin : g_mid
            assign r_val = val_w[i+1];
        end

        smq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .key       (key),
            .occ       (occ),
            .left_lt   (l_lt),
            .left_val  (l_val),
            .right_val (r_val),
            .val       (val_w[i]),
            .lt        (lt_w[i])
        );
    end

    assign head  = val_w[0];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign last  = (count_reg == CW'(1));

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins && !cmd.pop)
            count_next = count_reg + CW'(1);
        else if (cmd.pop && !cmd.ins)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

### hdl/sorted_multi_queue_move_engine_top.sv
// top level: command decode, queue chains and result register
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | operation, queue_sel, dest_sel, value
//  out      | out_valid / out_ready| out_value, was_empty, was_full, now_empty
//
// a word is captured in ST_IDLE; in ST_EXEC every cell of the affected chains
// compares against the key and shifts in parallel.
// a move pops the source head and inserts it into the destination in the same cycle.
// reset spares only the cells, which are never read before written.
// the execute cycle waits while the result register still holds an untaken word;
// a new word is captured while a finished result waits to be taken.
module sorted_multi_queue_move_engine_top
    import smq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  smq_pkg::op_t                 operation,
    input  smq_pkg::sel_t                queue_sel,
    input  smq_pkg::sel_t                dest_sel,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_value,
    output logic                         was_empty,
    output logic                         was_full,
    output logic                         now_empty
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    op_t                          op_reg;
    sel_t                         src_reg;
    sel_t                         dst_reg;
    logic signed [DATA_WIDTH-1:0] val_reg;

    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] out_value_reg;
    logic                         was_empty_reg;
    logic                         was_full_reg;
    logic                         now_empty_reg;

    logic signed [DATA_WIDTH-1:0] head_w  [NUM_QUEUES];
    logic                         empty_w [NUM_QUEUES];
    logic                         full_w  [NUM_QUEUES];
    logic                         last_w  [NUM_QUEUES];

    logic                         fire;
    logic                         src_ok;
    logic                         dst_ok;
    logic                         same_q;
    logic signed [DATA_WIDTH-1:0] src_head;
    logic                         src_empty;
    logic                         src_full;
    logic                         src_last;
    logic                         dst_full;
    logic                         do_ins;
    logic                         do_pop;
    logic                         move_go;
    logic signed [DATA_WIDTH-1:0] key;
    logic signed [DATA_WIDTH-1:0] res_value;
    logic                         res_was_empty;
    logic                         res_was_full;
    logic                         res_now_empty;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign was_empty = was_empty_reg;
    assign was_full  = was_full_reg;
    assign now_empty = now_empty_reg;

    assign fire   = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign src_ok = ({2'b00, src_reg} < 4'(NUM_QUEUES));
    assign dst_ok = ({2'b00, dst_reg} < 4'(NUM_QUEUES));
    assign same_q = (src_reg == dst_reg);

    // status of the selected source and destination queues
    always_comb
    begin
        src_head  = '0;
        src_empty = 1'b1;
        src_full  = 1'b0;
        src_last  = 1'b0;
        dst_full  = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if ({1'b0, src_reg} == 3'(q))
            begin
                src_head  = head_w[q];
                src_empty = empty_w[q];
                src_full  = full_w[q];
                src_last  = last_w[q];
            end
            if ({1'b0, dst_reg} == 3'(q))
                dst_full = full_w[q];
        end
    end

    // operation decode and result word
    always_comb
    begin
        do_ins        = 1'b0;
        do_pop        = 1'b0;
        move_go       = 1'b0;
        key           = val_reg;
        res_value     = '0;
        res_was_empty = src_empty;
        res_was_full  = 1'b0;
        res_now_empty = src_empty;
        if (!src_ok)
        begin
            res_was_empty = 1'b1;
            res_now_empty = 1'b1;
        end
        else
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (src_full)
                    begin
                        res_was_full = 1'b1;
                    end
                    else
                    begin
                        do_ins        = 1'b1;
                        res_now_empty = 1'b0;
                    end
                end
                OP_POP:
                begin
                    if (!src_empty)
                    begin
                        do_pop        = 1'b1;
                        res_value     = src_head;
                        res_now_empty = src_last;
                    end
                end
                OP_MOVE:
                begin
                    key = src_head;
                    if (dst_ok && !src_empty)
                    begin
                        if (same_q)
                        begin
                            res_value = src_head;
                        end
                        else if (dst_full)
                        begin
                            res_was_full = 1'b1;
                        end
                        else
                        begin
                            move_go       = 1'b1;
                            res_value     = src_head;
                            res_now_empty = src_last;
                        end
                    end
                end
                default:
                begin
                    res_value = '0;
                end
            endcase
        end
    end

    // queue chains with their per-queue commands
    for (genvar q = 0; q < NUM_QUEUES; q++)
    begin : g_queue
        smq_cmd_t cmd;
        logic     sel_src;
        logic     sel_dst;

        assign sel_src = ({1'b0, src_reg} == 3'(q));
        assign sel_dst = ({1'b0, dst_reg} == 3'(q));
        assign cmd.ins = fire && ((do_ins && sel_src) || (move_go && sel_dst));
        assign cmd.pop = fire && sel_src && (do_pop || move_go);

        smq_chain #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .DATA_WIDTH  (DATA_WIDTH)
        ) u_chain (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .key   (key),
            .head  (head_w[q]),
            .empty (empty_w[q]),
            .full  (full_w[q]),
            .last  (last_w[q])
        );
    end

    // control state, captured command and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_INSERT;
            src_reg       <= '0;
            dst_reg       <= '0;
            val_reg       <= '0;
            out_value_reg <= '0;
            was_empty_reg <= 1'b0;
            was_full_reg  <= 1'b0;
            now_empty_reg <= 1'b0;
        end
        else
        begin
            // result valid: set by a finished word, cleared when taken
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= operation;
                        src_reg   <= queue_sel;
                        dst_reg   <= dest_sel;
                        val_reg   <= value;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        out_value_reg <= res_value;
                        was_empty_reg <= res_was_empty;
                        was_full_reg  <= res_was_full;
                        now_empty_reg <= res_now_empty;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
